// ===== design/alfp_pkg.sv =====
// Shared types, constants and helpers for the ASCII length frame parser.
// No dependencies; every other design file imports this package.
package alfp_pkg;

    localparam int MAX_PAYLOAD = 65535;
    localparam int MAX_HEADER  = 8;

    localparam int HDR_BYTES_W = 8 * MAX_HEADER;
    localparam int HDR_LEN_W   = 4;
    localparam int HDR_IDX_W   = 3;
    localparam int LEN_W       = 17;   // holds MAX_PAYLOAD + 1
    localparam int ACC_W       = 21;   // length * 10 + 9 before saturation
    localparam int REM_W       = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [ACC_W-1:0] LEN_LIMIT = ACC_W'(MAX_PAYLOAD);
    localparam logic [LEN_W-1:0] LEN_SAT   = LEN_W'(MAX_PAYLOAD + 1);

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_DONE    = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_HEADER   = 3'd1;
    localparam logic [2:0] ERR_LENGTH   = 3'd2;
    localparam logic [2:0] ERR_NO_START = 3'd3;
    localparam logic [2:0] ERR_NO_END   = 3'd4;
    localparam logic [2:0] ERR_TOO_LONG = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTES = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_LEN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN_END      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_START   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_END     = 3'd4;

    typedef struct packed {
        logic [HDR_BYTES_W-1:0] header_bytes;
        logic [HDR_LEN_W-1:0]   header_length;
        logic [7:0]             length_end_char;
        logic [7:0]             data_start_char;
        logic [7:0]             data_end_char;
    } cfg_t;

    // one classified result on its way to the output stage
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [2:0] code;
    } token_t;

    typedef struct packed {
        logic              full;
        logic              nonempty;
        logic [QCNT_W-1:0] count;
    } queue_status_t;

    function automatic logic [7:0] hdr_byte(input logic [HDR_BYTES_W-1:0] hb,
                                            input logic [HDR_IDX_W-1:0] i);
        hdr_byte = hb[{i, 3'b000} +: 8];
    endfunction

    // header_length of 0 acts as 1, above MAX_HEADER acts as MAX_HEADER
    function automatic logic [HDR_LEN_W-1:0] hdr_len_eff(input logic [HDR_LEN_W-1:0] h);
        if (h == '0)
            hdr_len_eff = HDR_LEN_W'(1);
        else if (h > HDR_LEN_W'(MAX_HEADER))
            hdr_len_eff = HDR_LEN_W'(MAX_HEADER);
        else
            hdr_len_eff = h;
    endfunction

endpackage

// ===== design/alfp_front.sv =====
// Front end of the frame parser: takes received bytes, tracks the frame phase
// and classifies each byte into at most one result token. Uses alfp_pkg.
module alfp_front (
    input  logic                clk,
    input  logic                rst_n,
    input  alfp_pkg::cfg_t      cfg,
    input  logic                take,
    input  logic [7:0]          rx_byte,
    output logic                push,
    output alfp_pkg::token_t    token
);
    import alfp_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_HDR   = 3'd1,
        PH_LEN   = 3'd2,
        PH_START = 3'd3,
        PH_DATA  = 3'd4,
        PH_END   = 3'd5
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [HDR_IDX_W-1:0]   idx_reg, idx_next;
    logic [LEN_W-1:0]       len_reg, len_next;
    logic                   seen_reg, seen_next;
    logic [REM_W-1:0]       rem_reg, rem_next;

    logic [HDR_LEN_W-1:0]   n_eff;
    logic [HDR_IDX_W-1:0]   idx_inc;
    logic [ACC_W-1:0]       acc;
    logic [REM_W-1:0]       rem_dec;
    logic                   is_digit;

    assign n_eff    = hdr_len_eff(cfg.header_length);
    assign idx_inc  = idx_reg + HDR_IDX_W'(1);
    assign is_digit = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
    // length * 10 + digit as two shifts and adds
    assign acc      = {len_reg, 3'b000} + {2'b00, len_reg, 1'b0}
                      + ACC_W'(rx_byte - CHAR_ZERO);
    assign rem_dec  = rem_reg - REM_W'(1);

    always_comb
    begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        len_next   = len_reg;
        seen_next  = seen_reg;
        rem_next   = rem_reg;
        push       = 1'b0;
        token      = '{kind: KIND_ERROR, data: rx_byte, code: ERR_NONE};

        case (phase_reg)
            PH_HDR:
            begin
                if (rx_byte != hdr_byte(cfg.header_bytes, idx_reg))
                begin
                    push       = 1'b1;
                    token.code = ERR_HEADER;
                end
                else if (idx_inc == '0 || {1'b0, idx_inc} >= n_eff)
                begin
                    phase_next = PH_LEN;
                    idx_next   = '0;
                    len_next   = '0;
                    seen_next  = 1'b0;
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end
            PH_LEN:
            begin
                if (rx_byte == cfg.length_end_char)
                begin
                    if (!seen_reg)
                    begin
                        push       = 1'b1;
                        token.code = ERR_LENGTH;
                    end
                    else if (len_reg > LEN_W'(MAX_PAYLOAD))
                    begin
                        push       = 1'b1;
                        token.code = ERR_TOO_LONG;
                    end
                    else
                    begin
                        phase_next = PH_START;
                    end
                end
                else if (!is_digit)
                begin
                    push       = 1'b1;
                    token.code = ERR_LENGTH;
                end
                else
                begin
                    seen_next = 1'b1;
                    len_next  = (acc > LEN_LIMIT) ? LEN_SAT : acc[LEN_W-1:0];
                end
            end
            PH_START:
            begin
                if (rx_byte != cfg.data_start_char)
                begin
                    push       = 1'b1;
                    token.code = ERR_NO_START;
                end
                else
                begin
                    rem_next   = len_reg[REM_W-1:0];
                    phase_next = (len_reg[REM_W-1:0] == '0) ? PH_END : PH_DATA;
                end
            end
            PH_DATA:
            begin
                push       = 1'b1;
                token.kind = KIND_PAYLOAD;
                rem_next   = rem_dec;
                if (rem_dec == '0)
                    phase_next = PH_END;
            end
            PH_END:
            begin
                push = 1'b1;
                if (rx_byte != cfg.data_end_char)
                    token.code = ERR_NO_END;
                else
                    token.kind = KIND_DONE;
            end
            default:
            begin
                if (rx_byte == hdr_byte(cfg.header_bytes, '0))
                begin
                    if (n_eff <= HDR_LEN_W'(1))
                    begin
                        phase_next = PH_LEN;
                        idx_next   = '0;
                        len_next   = '0;
                        seen_next  = 1'b0;
                    end
                    else
                    begin
                        phase_next = PH_HDR;
                        idx_next   = HDR_IDX_W'(1);
                    end
                end
                else
                begin
                    phase_next = PH_HUNT;
                    idx_next   = '0;
                    len_next   = '0;
                    seen_next  = 1'b0;
                    rem_next   = '0;
                end
            end
        endcase

        // every result ends the frame except a payload byte
        if (push && token.kind != KIND_PAYLOAD)
        begin
            phase_next = PH_HUNT;
            idx_next   = '0;
            len_next   = '0;
            seen_next  = 1'b0;
            rem_next   = '0;
        end

        if (!take)
            push = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            idx_reg   <= '0;
            len_reg   <= '0;
            seen_reg  <= 1'b0;
            rem_reg   <= '0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            len_reg   <= len_next;
            seen_reg  <= seen_next;
            rem_reg   <= rem_next;
        end
    end

endmodule

// ===== design/alfp_queue.sv =====
// Four-entry token queue between the parser front end and the output stage.
// Uses alfp_pkg for the token type and depth constants.
module alfp_queue (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  alfp_pkg::token_t           push_token,
    input  logic                       pop,
    output alfp_pkg::token_t           head,
    output alfp_pkg::queue_status_t    status
);
    import alfp_pkg::*;

    token_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push, do_pop;

    assign status.full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.nonempty = (count_reg != '0);
    assign status.count    = count_reg;
    assign head            = slot_reg[rd_ptr_reg];

    assign do_push = push && !status.full;
    assign do_pop  = pop && status.nonempty;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + QCNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_token;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
        end
    end

endmodule

// ===== design/alfp_back.sv =====
// Output stage: drains tokens from the queue into a registered result and
// forms the output fields from the token kind. Uses alfp_pkg.
module alfp_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  alfp_pkg::token_t           head,
    input  logic                       head_valid,
    output logic                       pop,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [1:0]                 kind,
    output logic [7:0]                 payload_byte,
    output logic [2:0]                 error_code
);
    import alfp_pkg::*;

    logic        valid_reg;
    logic [1:0]  kind_reg;
    logic [7:0]  byte_reg;
    logic [2:0]  code_reg;

    assign pop          = head_valid && (!valid_reg || !out_stall);
    assign out_valid    = valid_reg;
    assign kind         = kind_reg;
    assign payload_byte = byte_reg;
    assign error_code   = code_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (pop)
            valid_reg <= 1'b1;
        else if (!out_stall)
            valid_reg <= 1'b0;
    end

    // fields that do not belong to the kind read as zero
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg <= head.kind;
            byte_reg <= (head.kind == KIND_PAYLOAD) ? head.data : 8'h00;
            code_reg <= (head.kind == KIND_ERROR) ? head.code : ERR_NONE;
        end
    end

endmodule

// ===== design/ascii_length_frame_parser.sv =====
// Channel   Direction  Handshake            Payload
// in        input      in_valid/in_stall    rx_byte
// out       output     out_valid/out_stall  kind, payload_byte, error_code
// cfg       input      cfg_we               cfg_index, cfg_data
//
// One byte per cycle is accepted while in_stall is low; the parser state
// updates in the cycle of the transaction. A result goes through the queue
// and then the output register. in_stall rises only while the four-entry
// queue is full, so a held output takes the result in the output register
// plus four queued ones before the input sees it. Reset clears the phase,
// counters and queue and returns the config to its defaults.
//
// Top level of the frame parser: configuration registers, front end, queue and
// output stage. Depends on alfp_pkg, alfp_front, alfp_queue and alfp_back.
module ascii_length_frame_parser (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [7:0]                         rx_byte,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [1:0]                         kind,
    output logic [7:0]                         payload_byte,
    output logic [2:0]                         error_code,
    input  logic                               cfg_we,
    input  logic [alfp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [alfp_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import alfp_pkg::*;

    cfg_t            cfg_reg;
    logic            take;
    logic            push;
    token_t          push_token;
    token_t          head;
    queue_status_t   q_status;
    logic            pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_bytes    <= '0;
            cfg_reg.header_length   <= HDR_LEN_W'(1);
            cfg_reg.length_end_char <= '0;
            cfg_reg.data_start_char <= '0;
            cfg_reg.data_end_char   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HEADER_BYTES: cfg_reg.header_bytes    <= cfg_data[HDR_BYTES_W-1:0];
                CFG_HEADER_LEN:   cfg_reg.header_length   <= cfg_data[HDR_LEN_W-1:0];
                CFG_LEN_END:      cfg_reg.length_end_char <= cfg_data[7:0];
                CFG_DATA_START:   cfg_reg.data_start_char <= cfg_data[7:0];
                CFG_DATA_END:     cfg_reg.data_end_char   <= cfg_data[7:0];
                default:          ;
            endcase
        end
    end

    assign in_stall = q_status.full;
    assign take     = in_valid && !in_stall;

    alfp_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .take    (take),
        .rx_byte (rx_byte),
        .push    (push),
        .token   (push_token)
    );

    alfp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_token (push_token),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    alfp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .head_valid   (q_status.nonempty),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .payload_byte (payload_byte),
        .error_code   (error_code)
    );

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_error_field: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_ERROR |-> error_code == ERR_NONE)
        else $error("error code set on a non-error result");

    a_payload_field: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_PAYLOAD |-> payload_byte == 8'h00)
        else $error("payload byte set on a non-payload result");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (kind == KIND_PAYLOAD) || (kind == KIND_DONE) || (kind == KIND_ERROR))
        else $error("illegal result kind");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for ascii_length_frame_parser: directed byte table, then random frames.
// Depends on alfp_pkg and the parser RTL; expected results come from a local frame predictor.
module tb_top;
    import alfp_pkg::*;

    localparam int CLK_HALF          = 4;
    localparam int DEC_BASE          = 10;
    localparam int SETTLE_CYCLES     = 8;
    localparam int HOLD_CYCLES       = 60;
    localparam int NUM_SETTINGS      = 9;
    localparam int ITEMS_PER_SETTING = 214;
    localparam int LIMIT_CYCLES      = 600000;
    localparam int MAX_PRINTS        = 30;

    typedef enum logic [2:0] {PH_HUNT, PH_HDR, PH_LEN, PH_START, PH_DATA, PH_END} parse_ph_t;
    typedef enum logic [1:0] {CHK_MODEL, CHK_QUIET, CHK_RESULT} chk_t;

    typedef struct {
        bit                   is_reg;
        logic [CFG_IDX_W-1:0] idx;
        logic [63:0]          val;
        logic [7:0]           b;
        chk_t                 chk;
        token_t               res;
    } step_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [7:0]            rx_byte = 8'h00;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [1:0]            kind;
    logic [7:0]            payload_byte;
    logic [2:0]            error_code;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // how the current transaction is to be checked (directed rows may type the result in)
    chk_t   note_chk = CHK_MODEL;
    token_t note_res = '0;

    // register shadow, reset values
    logic [63:0] cfg_hdr = '0;
    logic [3:0]  cfg_hlen = 4'd1;
    logic [7:0]  cfg_lend = '0;
    logic [7:0]  cfg_dstart = '0;
    logic [7:0]  cfg_dend = '0;

    // parser state as predicted
    parse_ph_t   ps_phase = PH_HUNT;
    logic [2:0]  ps_hidx = '0;
    logic [16:0] ps_len = '0;
    logic        ps_digit = 1'b0;
    logic [15:0] ps_left = '0;

    token_t      expected_q[$];
    step_t       plan_q[$];
    logic [7:0]  frame_q[$];
    int unsigned noise_len;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_hold = 0;
    int mismatch_cnt = 0;
    int cycle_cnt = 0;
    int n_in = 0;
    int n_payload = 0;
    int n_done = 0;
    int n_error = 0;

    ascii_length_frame_parser DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .payload_byte (payload_byte),
        .error_code   (error_code),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // ---------------- predictor ----------------

    function automatic logic [3:0] eff_hdr_len();
        if (cfg_hlen == '0)
            return 4'd1;
        if (cfg_hlen > 4'(MAX_HEADER))
            return 4'(MAX_HEADER);
        return cfg_hlen;
    endfunction

    function automatic void go_hunt();
        ps_phase = PH_HUNT;
        ps_hidx  = '0;
        ps_len   = '0;
        ps_digit = 1'b0;
        ps_left  = '0;
    endfunction

    function automatic void start_length();
        ps_phase = PH_LEN;
        ps_hidx  = '0;
        ps_len   = '0;
        ps_digit = 1'b0;
    endfunction

    function automatic token_t frame_error(input logic [2:0] err);
        go_hunt();
        return '{KIND_ERROR, 8'h00, err};
    endfunction

    // advance the parser by one byte; returns 1 when the byte yields a result
    function automatic bit parse_byte(input logic [7:0] b, output token_t res);
        logic [20:0] acc;
        logic [3:0]  n;
        bit          hit;
        n   = eff_hdr_len();
        res = '0;
        hit = 1'b0;
        case (ps_phase)
            PH_HDR:
            begin
                if (b != cfg_hdr[{ps_hidx, 3'b000} +: 8])
                begin
                    res = frame_error(ERR_HEADER);
                    hit = 1'b1;
                end
                else
                begin
                    ps_hidx = ps_hidx + 3'd1;
                    if (ps_hidx == '0 || 4'(ps_hidx) >= n)
                        start_length();
                end
            end
            PH_LEN:
            begin
                // end char wins over the digit test
                if (b == cfg_lend)
                begin
                    if (!ps_digit)
                    begin
                        res = frame_error(ERR_LENGTH);
                        hit = 1'b1;
                    end
                    else if (ps_len > 17'(MAX_PAYLOAD))
                    begin
                        res = frame_error(ERR_TOO_LONG);
                        hit = 1'b1;
                    end
                    else
                        ps_phase = PH_START;
                end
                else if (b < CHAR_ZERO || b > CHAR_NINE)
                begin
                    res = frame_error(ERR_LENGTH);
                    hit = 1'b1;
                end
                else
                begin
                    ps_digit = 1'b1;
                    acc = 21'(ps_len) * 21'(DEC_BASE) + 21'(b - CHAR_ZERO);
                    ps_len = (acc > 21'(MAX_PAYLOAD)) ? 17'(MAX_PAYLOAD + 1) : acc[16:0];
                end
            end
            PH_START:
            begin
                if (b != cfg_dstart)
                begin
                    res = frame_error(ERR_NO_START);
                    hit = 1'b1;
                end
                else
                begin
                    ps_left  = ps_len[15:0];
                    ps_phase = (ps_left == '0) ? PH_END : PH_DATA;
                end
            end
            PH_DATA:
            begin
                ps_left = ps_left - 16'd1;
                if (ps_left == '0)
                    ps_phase = PH_END;
                res = '{KIND_PAYLOAD, b, ERR_NONE};
                hit = 1'b1;
            end
            PH_END:
            begin
                if (b != cfg_dend)
                    res = frame_error(ERR_NO_END);
                else
                begin
                    go_hunt();
                    res = '{KIND_DONE, 8'h00, ERR_NONE};
                end
                hit = 1'b1;
            end
            default:
            begin
                if (b == cfg_hdr[7:0])
                begin
                    if (n <= 4'd1)
                        start_length();
                    else
                    begin
                        ps_phase = PH_HDR;
                        ps_hidx  = 3'd1;
                    end
                end
                else
                    go_hunt();
            end
        endcase
        return hit;
    endfunction

    // ---------------- checking ----------------

    task automatic log_mismatch(input string what, input int got, input int want);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_PRINTS)
            $display("MISMATCH cycle %0d: %s got 0x%0h want 0x%0h", cycle_cnt, what, got, want);
    endtask

    always @(posedge clk)
    begin : monitor
        token_t want;
        token_t exp_head;
        bit     has;
        if (rst_n && in_valid && in_stall === 1'b0)
        begin
            n_in++;
            has = parse_byte(rx_byte, want);
            case (note_chk)
                CHK_QUIET:  has = 1'b0;
                CHK_RESULT:
                begin
                    has  = 1'b1;
                    want = note_res;
                end
                default: ;
            endcase
            if (has)
                expected_q = {expected_q, want};
        end
        if (rst_n && out_valid === 1'b1 && !out_stall)
        begin
            case (kind)
                KIND_PAYLOAD: n_payload++;
                KIND_DONE:    n_done++;
                default:      n_error++;
            endcase
            if (expected_q.size() == 0)
                log_mismatch("result with nothing expected, kind", kind, 0);
            else
            begin
                exp_head = expected_q.pop_front();
                if (kind !== exp_head.kind)
                    log_mismatch("kind", kind, exp_head.kind);
                if (payload_byte !== exp_head.data)
                    log_mismatch("payload_byte", payload_byte, exp_head.data);
                if (error_code !== exp_head.code)
                    log_mismatch("error_code", error_code, exp_head.code);
            end
        end
    end

    // receiver: random stalls, plus a long hold-off counted down here
    always @(posedge clk)
    begin
        if (stall_hold > 0)
        begin
            stall_hold = stall_hold - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= LIMIT_CYCLES)
        begin
            $display("ascii_length_frame_parser test failed");
            $finish;
        end
    end

    // ---------------- driving ----------------

    task automatic send_byte(input logic [7:0] b, input chk_t chk, input token_t res);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        note_chk <= chk;
        note_res <= res;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
    endtask

    // caller lowers cfg_we after the last write of a batch
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_HEADER_BYTES: cfg_hdr    = val;
            CFG_HEADER_LEN:   cfg_hlen   = val[3:0];
            CFG_LEN_END:      cfg_lend   = val[7:0];
            CFG_DATA_START:   cfg_dstart = val[7:0];
            CFG_DATA_END:     cfg_dend   = val[7:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic void plan_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        step_t s;
        s = '{1'b1, idx, val, 8'h00, CHK_MODEL, '0};
        plan_q = {plan_q, s};
    endfunction

    function automatic void plan_byte(input logic [7:0] b, input chk_t chk);
        step_t s;
        s = '{1'b0, '0, '0, b, chk, '0};
        plan_q = {plan_q, s};
    endfunction

    function automatic void plan_result(input logic [7:0] b, input logic [1:0] k,
                                        input logic [7:0] d, input logic [2:0] c);
        step_t s;
        s = '{1'b0, '0, '0, b, CHK_RESULT, '{k, d, c}};
        plan_q = {plan_q, s};
    endfunction

    function automatic void frame_add(input logic [7:0] b);
        frame_q = {frame_q, b};
    endfunction

    // One frame into frame_q: mostly well formed, some broken, some line noise.
    task automatic build_frame(input bit fill);
        int unsigned style;
        int unsigned v;
        int unsigned pos;
        int unsigned nhdr;
        logic [7:0]  nb;
        logic [7:0]  digs[$];
        frame_q.delete();
        noise_len = 0;
        nhdr  = eff_hdr_len();
        style = fill ? 0 : $urandom_range(99);
        if (style >= 90)
        begin
            repeat ($urandom_range(6, 1)) frame_add(8'($urandom));
            noise_len = frame_q.size();
            return;
        end
        repeat ($urandom_range(2))
        begin
            nb = 8'($urandom);
            if (nb == cfg_hdr[7:0])
                nb ^= 8'h01;
            frame_add(nb);
        end
        noise_len = frame_q.size();
        for (int i = 0; i < nhdr; i++)
            frame_add(cfg_hdr[8*i +: 8]);
        if (style >= 68 && style < 72)
        begin
            frame_add(cfg_lend);   // empty length field
            return;
        end
        if (fill)
            v = 24;
        else if (style >= 72 && style < 75)
            v = MAX_PAYLOAD;
        else if (style == 75)
            v = MAX_PAYLOAD + 1;
        else if (style > 75 && style < 80)
            v = $urandom_range(9999999, MAX_PAYLOAD + 2);
        else if ($urandom_range(99) < 78)
            v = $urandom_range(12);
        else if ($urandom_range(99) < 80)
            v = $urandom_range(99, 13);
        else
            v = $urandom_range(600, 100);
        do
        begin
            digs.push_front(8'(CHAR_ZERO + v % DEC_BASE));
            v = v / DEC_BASE;
        end
        while (v != 0);
        if (style < 68 || style >= 80)
        begin
            if ($urandom_range(9) == 0)
                digs.push_front(CHAR_ZERO);
            // a digit end char would cut the length short
            if (cfg_lend >= CHAR_ZERO && cfg_lend <= CHAR_NINE)
                foreach (digs[i])
                    if (digs[i] == cfg_lend)
                        digs[i] = (cfg_lend == CHAR_NINE) ? CHAR_ZERO : cfg_lend + 8'd1;
        end
        v = 0;
        foreach (digs[i])
        begin
            frame_add(digs[i]);
            v = v * DEC_BASE + (digs[i] - CHAR_ZERO);
        end
        frame_add(cfg_lend);
        if (style >= 72 && style < 80)
        begin
            if (style < 75)
                frame_add(cfg_dstart ^ 8'h01);
            return;
        end
        frame_add(cfg_dstart);
        repeat (v) frame_add(8'($urandom));
        frame_add(cfg_dend);
        if (style >= 80 && style < 85)
            frame_q[frame_q.size() - 1] ^= 8'h01;
        else if (style >= 85)
        begin
            pos = $urandom_range(frame_q.size() - 1, noise_len + 1);
            frame_q[pos] ^= 8'(1 << $urandom_range(7));
        end
    endtask

    // ---------------- stimulus ----------------

    initial
    begin : stim
        int          k;
        int          sent;
        logic [63:0] hb;
        logic [3:0]  hl;
        logic [7:0]  le;
        logic [7:0]  ds;
        logic [7:0]  de;

        // after reset: header byte 0x00, one header byte, every delimiter 0x00
        plan_byte(8'h41, CHK_QUIET);
        plan_byte(8'h00, CHK_QUIET);
        plan_result(8'h00, KIND_ERROR, 8'h00, ERR_LENGTH);
        plan_reg(CFG_HEADER_BYTES, 64'hFFEE_DDCC_BBAA_A55A);
        plan_reg(CFG_HEADER_LEN, 64'd2);
        plan_reg(CFG_LEN_END, 64'h3A);
        plan_reg(CFG_DATA_START, 64'h02);
        plan_reg(CFG_DATA_END, 64'h03);
        plan_reg(3'(CFG_DATA_END + 1), 64'hFF);   // outside the map, ignored
        // two payload bytes at the byte extremes
        plan_byte(8'h5A, CHK_MODEL);
        plan_byte(8'hA5, CHK_MODEL);
        plan_byte(8'h32, CHK_MODEL);
        plan_byte(8'h3A, CHK_MODEL);
        plan_byte(8'h02, CHK_MODEL);
        plan_result(8'hFF, KIND_PAYLOAD, 8'hFF, ERR_NONE);
        plan_result(8'h00, KIND_PAYLOAD, 8'h00, ERR_NONE);
        plan_result(8'h03, KIND_DONE, 8'h00, ERR_NONE);
        // second header byte wrong
        plan_byte(8'h5A, CHK_MODEL);
        plan_result(8'h5A, KIND_ERROR, 8'h00, ERR_HEADER);
        // letter in the length field
        plan_byte(8'h5A, CHK_MODEL);
        plan_byte(8'hA5, CHK_MODEL);
        plan_result(8'h78, KIND_ERROR, 8'h00, ERR_LENGTH);
        // 70000 is over the payload limit
        plan_byte(8'h5A, CHK_MODEL);
        plan_byte(8'hA5, CHK_MODEL);
        plan_byte(8'h37, CHK_MODEL);
        plan_byte(8'h30, CHK_MODEL);
        plan_byte(8'h30, CHK_MODEL);
        plan_byte(8'h30, CHK_MODEL);
        plan_byte(8'h30, CHK_MODEL);
        plan_result(8'h3A, KIND_ERROR, 8'h00, ERR_TOO_LONG);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 12;
        recv_idle_pct = 65;
        foreach (plan_q[i])
        begin
            if (plan_q[i].is_reg)
            begin
                if (i == 0 || !plan_q[i-1].is_reg)
                    drain_results();
                write_reg(plan_q[i].idx, plan_q[i].val);
            end
            else
            begin
                if (i > 0 && plan_q[i-1].is_reg)
                    cfg_we <= 1'b0;
                send_byte(plan_q[i].b, plan_q[i].chk, plan_q[i].res);
            end
        end

        for (k = 0; k < NUM_SETTINGS; k++)
        begin
            drain_results();
            hb = {$urandom, $urandom};
            hl = 4'($urandom_range(15));
            le = 8'($urandom);
            ds = 8'($urandom);
            de = 8'($urandom);
            case (k)
                0:
                begin
                    hl = 4'd1;
                    le = 8'h3A;
                    ds = 8'h02;
                    de = 8'h03;
                end
                1:
                begin
                    // all zero; header length 0 behaves as 1
                    hb = '0;
                    hl = '0;
                    le = 8'h00;
                    ds = 8'h00;
                    de = 8'h00;
                end
                2:
                begin
                    hb = '1;
                    hl = 4'(MAX_HEADER);
                    le = 8'hFF;
                    ds = 8'hFF;
                    de = 8'hFF;
                end
                3:
                begin
                    // above the maximum header length, and a digit as length end
                    hl = 4'hF;
                    le = CHAR_ZERO + 8'd5;
                end
                4: hl = 4'($urandom_range(MAX_HEADER, 1));
                5: hl = 4'd4;
                default: ;
            endcase
            write_reg(CFG_HEADER_BYTES, hb);
            write_reg(CFG_HEADER_LEN, 64'(hl));
            write_reg(CFG_LEN_END, 64'(le));
            write_reg(CFG_DATA_START, 64'(ds));
            write_reg(CFG_DATA_END, 64'(de));
            write_reg(3'(CFG_DATA_END + 1 + $urandom_range(2)), {$urandom, $urandom});
            cfg_we <= 1'b0;

            case (k / 3)
                0:
                begin
                    send_idle_pct = 12;
                    recv_idle_pct = 65;
                end
                1:
                begin
                    send_idle_pct = 65;
                    recv_idle_pct = 12;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            // long output hold-off while a payload-heavy frame keeps coming
            if (k % 3 == 1)
                stall_hold = HOLD_CYCLES;

            // byte budget per setting; the last frame may be cut short
            sent = 0;
            while (sent < ITEMS_PER_SETTING)
            begin
                build_frame(k % 3 == 1 && sent == 0);
                foreach (frame_q[i])
                begin
                    if (sent < ITEMS_PER_SETTING)
                    begin
                        send_byte(frame_q[i], CHK_MODEL, '0);
                        sent++;
                    end
                end
            end
        end
        drain_results();

        $display("Run covered %0d input bytes over %0d register settings,", n_in, NUM_SETTINGS + 2);
        $display("with %0d payload bytes, %0d completed frames, %0d error reports, %0d mismatches.",
                 n_payload, n_done, n_error, mismatch_cnt);
        if (mismatch_cnt == 0 && expected_q.size() == 0)
            $display("ascii_length_frame_parser test passed");
        else
            $display("ascii_length_frame_parser test failed");
        $finish;
    end

endmodule
